// ===== design/dafs_pkg.sv =====
// Shared types, codes and reset values for the arming and failsafe sequencer.
package dafs_pkg;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_ARMING   = 3'd1;
  localparam logic [2:0] MODE_ARMED    = 3'd2;
  localparam logic [2:0] MODE_FLYING   = 3'd3;
  localparam logic [2:0] MODE_FAILSAFE = 3'd4;
  localparam logic [2:0] MODE_LANDING  = 3'd5;
  localparam logic [2:0] MODE_ERROR    = 3'd6;

  localparam logic [1:0] CMD_KEEP = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_MIX  = 2'd2;

  localparam logic [2:0] REG_ARM_HOLD     = 3'd0;
  localparam logic [2:0] REG_LINK_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_RAMP_STEP_MS = 3'd2;
  localparam logic [2:0] REG_RAMP_STEP_PC = 3'd3;
  localparam logic [2:0] REG_FLY_THRESH   = 3'd4;
  localparam logic [2:0] REG_HOLD_PCT     = 3'd5;

  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_ARMING   = 7'b0000010,
    ST_ARMED    = 7'b0000100,
    ST_FLYING   = 7'b0001000,
    ST_FAILSAFE = 7'b0010000,
    ST_LANDING  = 7'b0100000,
    ST_ERROR    = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [15:0] arm_hold_ms;
    logic [15:0] link_loss_timeout_ms;
    logic [15:0] ramp_step_ms;
    logic [6:0]  ramp_step_pct;
    logic [9:0]  fly_threshold;
    logic [6:0]  hold_pct;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    arm_hold_ms:          16'd500,
    link_loss_timeout_ms: 16'd2000,
    ramp_step_ms:         16'd200,
    ramp_step_pct:        7'd2,
    fly_threshold:        10'd50,
    hold_pct:             7'd25
  };

  typedef struct packed {
    mode_t       mode;
    logic [31:0] entry_time;
    logic [6:0]  ramp_level;
    logic [31:0] ramp_time;
  } state_t;

  typedef struct packed {
    logic        link_active;
    logic [9:0]  throttle;
    logic [31:0] now_ms;
    logic        hw_fault;
  } tick_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] motor_cmd;
    logic [6:0] motor_pct;
  } res_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      ST_IDLE:     c = MODE_IDLE;
      ST_ARMING:   c = MODE_ARMING;
      ST_ARMED:    c = MODE_ARMED;
      ST_FLYING:   c = MODE_FLYING;
      ST_FAILSAFE: c = MODE_FAILSAFE;
      ST_LANDING:  c = MODE_LANDING;
      default:     c = MODE_ERROR;
    endcase
    return c;
  endfunction

endpackage

// ===== design/dafs_if.sv =====
// Valid/ready channel interfaces for ticks and results.
interface dafs_tick_if;
  logic        valid;
  logic        ready;
  logic        link_active;
  logic [9:0]  throttle;
  logic [31:0] now_ms;
  logic        hw_fault;

  modport source (output valid, link_active, throttle, now_ms, hw_fault, input ready);
  modport sink   (input valid, link_active, throttle, now_ms, hw_fault, output ready);
endinterface

interface dafs_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [1:0] motor_cmd;
  logic [6:0] motor_pct;

  modport source (output valid, mode, motor_cmd, motor_pct, input ready);
  modport sink   (input valid, mode, motor_cmd, motor_pct, output ready);
endinterface

// ===== design/dafs_step.sv =====
// Next-state and result logic for one tick of the sequencer.
module dafs_step
  import dafs_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t st,
  input  tick_t  tk,
  output state_t nxt,
  output res_t   res
);

  logic [31:0] elapsed;
  logic [31:0] since_step;
  logic [6:0]  hold_eff;
  logic [6:0]  step;
  logic        arm_ok;
  mode_t       cur;

  assign elapsed    = tk.now_ms - st.entry_time;
  assign since_step = tk.now_ms - st.ramp_time;
  assign hold_eff   = (cfg.hold_pct > PCT_MAX) ? PCT_MAX : cfg.hold_pct;
  assign step       = (cfg.ramp_step_pct == 7'd0) ? 7'd1 : cfg.ramp_step_pct;
  assign arm_ok     = tk.link_active && (tk.throttle == 10'd0);

  always_comb begin
    nxt           = st;
    res.motor_cmd = CMD_KEEP;
    res.motor_pct = 7'd0;
    cur           = st.mode;
    if (tk.hw_fault && st.mode != ST_ERROR) begin
      cur            = ST_ERROR;
      nxt.mode       = ST_ERROR;
      nxt.entry_time = tk.now_ms;
    end
    case (cur)
      ST_IDLE: begin
        res.motor_cmd = CMD_SET;
        if (arm_ok) begin
          nxt.mode       = ST_ARMING;
          nxt.entry_time = tk.now_ms;
        end
      end
      ST_ARMING: begin
        res.motor_cmd = CMD_SET;
        if (!arm_ok) begin
          nxt.mode       = ST_IDLE;
          nxt.entry_time = tk.now_ms;
        end else if (elapsed >= {16'd0, cfg.arm_hold_ms}) begin
          nxt.mode       = ST_ARMED;
          nxt.entry_time = tk.now_ms;
        end
      end
      ST_ARMED: begin
        res.motor_cmd = CMD_SET;
        if (!tk.link_active) begin
          nxt.mode       = ST_IDLE;
          nxt.entry_time = tk.now_ms;
        end else if (tk.throttle > cfg.fly_threshold) begin
          nxt.mode       = ST_FLYING;
          nxt.entry_time = tk.now_ms;
        end
      end
      ST_FLYING: begin
        if (!tk.link_active) begin
          nxt.mode       = ST_FAILSAFE;
          nxt.entry_time = tk.now_ms;
        end else if (tk.throttle == 10'd0) begin
          res.motor_cmd  = CMD_SET;
          nxt.mode       = ST_ARMED;
          nxt.entry_time = tk.now_ms;
        end else begin
          res.motor_cmd = CMD_MIX;
        end
      end
      ST_FAILSAFE: begin
        if (tk.link_active) begin
          nxt.mode       = ST_FLYING;
          nxt.entry_time = tk.now_ms;
        end else if (elapsed >= {16'd0, cfg.link_loss_timeout_ms}) begin
          nxt.ramp_level = hold_eff;
          nxt.ramp_time  = tk.now_ms;
          nxt.mode       = ST_LANDING;
          nxt.entry_time = tk.now_ms;
        end else begin
          res.motor_cmd = CMD_SET;
          res.motor_pct = hold_eff;
        end
      end
      ST_LANDING: begin
        if (st.ramp_level == 7'd0) begin
          res.motor_cmd  = CMD_SET;
          nxt.mode       = ST_IDLE;
          nxt.entry_time = tk.now_ms;
        end else if (since_step >= {16'd0, cfg.ramp_step_ms}) begin
          nxt.ramp_level = (st.ramp_level > step) ? (st.ramp_level - step) : 7'd0;
          res.motor_cmd  = CMD_SET;
          res.motor_pct  = nxt.ramp_level;
          nxt.ramp_time  = tk.now_ms;
        end
      end
      default: begin
        nxt.mode      = ST_ERROR;
        res.motor_cmd = CMD_SET;
      end
    endcase
    res.mode = mode_code(nxt.mode);
  end

endmodule

// ===== design/drone_arming_failsafe_fsm.sv =====
// Flight safety sequencer top level: arming, failsafe, landing ramp and fault lock.
// Takes one tick request per clock while the result side does not stall and gives one result
// per tick, valid once the tick has passed the input register and then the result register.
// The mode, entry time and ramp state update with the result register, so back-to-back ticks
// see each other's effects without stalls; the only stalls come from the result side.
// The user writes registers only while the block is idle (unenforced); they reset to defaults.
module drone_arming_failsafe_fsm
  import dafs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  dafs_tick_if.sink    tick,
  dafs_res_if.source   result,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  tick_t  t_data;
  logic   t_valid;
  res_t   r_data;
  res_t   r_next;
  logic   r_valid;
  logic   advance;

  assign advance    = t_valid && (!r_valid || result.ready);
  assign tick.ready = !t_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARM_HOLD:     cfg.arm_hold_ms          <= cfg_data;
        REG_LINK_TIMEOUT: cfg.link_loss_timeout_ms <= cfg_data;
        REG_RAMP_STEP_MS: cfg.ramp_step_ms         <= cfg_data;
        REG_RAMP_STEP_PC: cfg.ramp_step_pct        <= cfg_data[6:0];
        REG_FLY_THRESH:   cfg.fly_threshold        <= cfg_data[9:0];
        REG_HOLD_PCT:     cfg.hold_pct             <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      t_data <= '{link_active: tick.link_active, throttle: tick.throttle,
                  now_ms: tick.now_ms, hw_fault: tick.hw_fault};
    end
    if (advance) begin
      r_data <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      r_valid <= 1'b0;
      st      <= '{mode: ST_IDLE, entry_time: 32'd0, ramp_level: 7'd0, ramp_time: 32'd0};
    end else begin
      if (tick.ready) begin
        t_valid <= tick.valid;
      end
      if (advance) begin
        r_valid <= 1'b1;
        st      <= st_next;
      end else if (result.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  dafs_step u_step (
    .cfg (cfg),
    .st  (st),
    .tk  (t_data),
    .nxt (st_next),
    .res (r_next)
  );

  assign result.valid     = r_valid;
  assign result.mode      = r_data.mode;
  assign result.motor_cmd = r_data.motor_cmd;
  assign result.motor_pct = r_data.motor_pct;

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    st.mode == ST_ERROR |=> st.mode == ST_ERROR)
    else $error("error mode left without reset");

  a_fault_reports_error: assert property (@(posedge clk) disable iff (rst)
    advance && t_data.hw_fault |=> result.valid && result.mode == MODE_ERROR)
    else $error("fault tick did not report error");

  a_pct_only_with_set: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.motor_cmd != CMD_SET |-> result.motor_pct == 7'd0)
    else $error("motor percent set without set command");

  a_ramp_in_range: assert property (@(posedge clk) disable iff (rst)
    st.ramp_level <= PCT_MAX)
    else $error("ramp level above full scale");

  a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("state changed without a tick");

endmodule

// ===== sim/tb_drone_arming_failsafe_fsm.sv =====
`timescale 1ns / 1ps
// Testbench for the arming and failsafe sequencer: scripted flights and noise checked per tick.
module tb_drone_arming_failsafe_fsm;
  import dafs_pkg::*;

  localparam int LIMIT = 200000;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dafs_tick_if tick_ch();
  dafs_res_if  res_ch();

  drone_arming_failsafe_fsm dut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .result(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  cfg_t        cfg_now = CFG_RESET;
  logic [2:0]  seq_mode = MODE_IDLE;
  logic [31:0] seq_entry = '0;
  logic [6:0]  seq_ramp = '0;
  logic [31:0] seq_ramp_time = '0;

  tick_t       tick_backlog[$];
  res_t        due_results[$];
  logic [31:0] sim_ms = '0;
  int          ticks_queued = 0;
  int          errors = 0;
  int          cycles = 0;
  bit          offering = 1'b0;
  bit          quiet = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          stall_left = 0;
  int          stall_req = 0;
  int          stall_seen = 0;

  function automatic void enter_mode(logic [2:0] m, logic [31:0] now);
    seq_mode = m;
    seq_entry = now;
  endfunction

  function automatic res_t sequence_tick(tick_t t);
    res_t        r;
    logic        arm_ok;
    logic [31:0] elapsed;
    logic [6:0]  hold;
    logic [6:0]  step;
    r.motor_cmd = CMD_KEEP;
    r.motor_pct = '0;
    arm_ok = t.link_active && t.throttle == 10'd0;
    elapsed = t.now_ms - seq_entry;
    hold = (cfg_now.hold_pct > PCT_MAX) ? PCT_MAX : cfg_now.hold_pct;
    step = (cfg_now.ramp_step_pct == 7'd0) ? 7'd1 : cfg_now.ramp_step_pct;
    if (t.hw_fault && seq_mode != MODE_ERROR) enter_mode(MODE_ERROR, t.now_ms);
    case (seq_mode)
      MODE_IDLE: begin
        r.motor_cmd = CMD_SET;
        if (arm_ok) enter_mode(MODE_ARMING, t.now_ms);
      end
      MODE_ARMING: begin
        r.motor_cmd = CMD_SET;
        if (!arm_ok) enter_mode(MODE_IDLE, t.now_ms);
        else if (elapsed >= 32'(cfg_now.arm_hold_ms)) enter_mode(MODE_ARMED, t.now_ms);
      end
      MODE_ARMED: begin
        r.motor_cmd = CMD_SET;
        if (!t.link_active) enter_mode(MODE_IDLE, t.now_ms);
        else if (t.throttle > cfg_now.fly_threshold) enter_mode(MODE_FLYING, t.now_ms);
      end
      MODE_FLYING: begin
        if (!t.link_active) begin
          enter_mode(MODE_FAILSAFE, t.now_ms);
        end else if (t.throttle == 10'd0) begin
          r.motor_cmd = CMD_SET;
          enter_mode(MODE_ARMED, t.now_ms);
        end else begin
          r.motor_cmd = CMD_MIX;
        end
      end
      MODE_FAILSAFE: begin
        if (t.link_active) begin
          enter_mode(MODE_FLYING, t.now_ms);
        end else if (elapsed >= 32'(cfg_now.link_loss_timeout_ms)) begin
          seq_ramp = hold;
          seq_ramp_time = t.now_ms;
          enter_mode(MODE_LANDING, t.now_ms);
        end else begin
          r.motor_cmd = CMD_SET;
          r.motor_pct = hold;
        end
      end
      MODE_LANDING: begin
        if (seq_ramp == 7'd0) begin
          r.motor_cmd = CMD_SET;
          enter_mode(MODE_IDLE, t.now_ms);
        end else if (t.now_ms - seq_ramp_time >= 32'(cfg_now.ramp_step_ms)) begin
          seq_ramp = (seq_ramp > step) ? seq_ramp - step : 7'd0;
          r.motor_cmd = CMD_SET;
          r.motor_pct = seq_ramp;
          seq_ramp_time = t.now_ms;
        end
      end
      default: begin
        seq_mode = MODE_ERROR;
        r.motor_cmd = CMD_SET;
      end
    endcase
    r.mode = seq_mode;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_ARM_HOLD:     cfg_now.arm_hold_ms = data;
      REG_LINK_TIMEOUT: cfg_now.link_loss_timeout_ms = data;
      REG_RAMP_STEP_MS: cfg_now.ramp_step_ms = data;
      REG_RAMP_STEP_PC: cfg_now.ramp_step_pct = data[6:0];
      REG_FLY_THRESH:   cfg_now.fly_threshold = data[9:0];
      REG_HOLD_PCT:     cfg_now.hold_pct = data[6:0];
      default: ;
    endcase
  endtask

  // junk sets the bits above each narrow register's width
  task automatic load_settings(cfg_t c, bit junk);
    logic [15:0] hi;
    hi = junk ? 16'($urandom) : 16'd0;
    write_reg(REG_ARM_HOLD, c.arm_hold_ms);
    write_reg(REG_LINK_TIMEOUT, c.link_loss_timeout_ms);
    write_reg(REG_RAMP_STEP_MS, c.ramp_step_ms);
    write_reg(REG_RAMP_STEP_PC, {hi[15:7], c.ramp_step_pct});
    write_reg(REG_FLY_THRESH, {hi[15:10], c.fly_threshold});
    write_reg(REG_HOLD_PCT, {hi[15:7], c.hold_pct});
    write_reg(REG_SPARE_6, 16'($urandom));
    write_reg(REG_SPARE_7, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.arm_hold_ms = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
    c.link_loss_timeout_ms = 16'($urandom_range(0, 5000));
    c.ramp_step_ms = 16'($urandom_range(0, 400));
    c.ramp_step_pct = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 20));
    c.fly_threshold = 10'($urandom);
    c.hold_pct = 7'($urandom);
    return c;
  endfunction

  task automatic drain();
    while (tick_backlog.size() != 0 || offering || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_tick(bit link, logic [9:0] thr, logic [31:0] dt, bit fault);
    tick_t t;
    sim_ms = sim_ms + dt;
    t.link_active = link;
    t.throttle = thr;
    t.now_ms = sim_ms;
    t.hw_fault = fault;
    tick_backlog.push_back(t);
    ticks_queued++;
  endtask

  function automatic logic [9:0] any_thr();
    case ($urandom_range(0, 3))
      0:       return 10'd0;
      1:       return 10'h3FF;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] above_thr();
    return 10'($urandom_range(32'(cfg_now.fly_threshold) + 1, 1023));
  endfunction

  // ticks spanning at least span ms, sometimes landing exactly on the boundary
  task automatic hold_span(bit link, logic [9:0] thr, logic [31:0] span);
    int          n;
    logic [31:0] piece;
    if (span != 0 && $urandom_range(0, 3) == 0) begin
      add_tick(link, thr, span - 1, 1'b0);
      add_tick(link, thr, 1, 1'b0);
    end else begin
      n = $urandom_range(1, 4);
      piece = span / n + 1;
      repeat (n) add_tick(link, thr, piece, 1'b0);
    end
  endtask

  // arm, fly, lose link, wait out failsafe, ramp down to idle
  task automatic fly_sortie();
    logic [6:0] hold;
    logic [6:0] step;
    int         steps;
    hold = (cfg_now.hold_pct > PCT_MAX) ? PCT_MAX : cfg_now.hold_pct;
    step = (cfg_now.ramp_step_pct == 7'd0) ? 7'd1 : cfg_now.ramp_step_pct;
    if ($urandom_range(0, 2) == 0)
      add_tick(1'($urandom), 10'($urandom_range(1, 1023)), $urandom_range(0, 50), 1'b0);
    add_tick(1'b1, 10'd0, $urandom_range(0, 20), 1'b0);
    if ($urandom_range(0, 5) == 0) begin
      add_tick(1'b1, 10'($urandom_range(1, 1023)), 1, 1'b0);
      add_tick(1'b1, 10'd0, 1, 1'b0);
    end
    hold_span(1'b1, 10'd0, cfg_now.arm_hold_ms);
    repeat ($urandom_range(0, 2))
      add_tick(1'b1, 10'($urandom_range(0, cfg_now.fly_threshold)), $urandom_range(0, 100), 1'b0);
    if (cfg_now.fly_threshold != 10'h3FF) add_tick(1'b1, above_thr(), $urandom_range(0, 50), 1'b0);
    repeat ($urandom_range(1, 4)) begin
      add_tick(1'b1, 10'($urandom_range(1, 1023)), $urandom_range(0, 100), 1'b0);
      if ($urandom_range(0, 4) == 0) begin
        add_tick(1'b1, 10'd0, $urandom_range(0, 100), 1'b0);
        if (cfg_now.fly_threshold != 10'h3FF) add_tick(1'b1, above_thr(), 1, 1'b0);
      end
    end
    add_tick(1'b0, any_thr(), $urandom_range(0, 50), 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      add_tick(1'b1, 10'($urandom_range(1, 1023)), 5, 1'b0);
      add_tick(1'b0, any_thr(), 5, 1'b0);
    end
    hold_span(1'b0, any_thr(), cfg_now.link_loss_timeout_ms);
    steps = (hold + step - 1) / step;
    repeat (steps) begin
      if ($urandom_range(0, 3) == 0)
        hold_span(1'($urandom), any_thr(), cfg_now.ramp_step_ms);
      else
        add_tick(1'($urandom), any_thr(), cfg_now.ramp_step_ms + $urandom_range(0, 3), 1'b0);
    end
    add_tick(1'($urandom), any_thr(), $urandom_range(0, 10), 1'b0);
  endtask

  task automatic noise_burst(bit faults);
    logic [31:0] dt;
    repeat ($urandom_range(1, 8)) begin
      dt = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 3000);
      add_tick(1'($urandom), any_thr(), dt, faults ? ($urandom_range(0, 3) == 0) : 1'b0);
    end
  endtask

  task automatic random_flights(int budget);
    int target;
    target = ticks_queued + budget;
    while (ticks_queued < target) begin
      if ($urandom_range(0, 9) < 7) fly_sortie();
      else noise_burst(1'b0);
    end
  endtask

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.link_active = 1'b0;
    tick_ch.throttle = '0;
    tick_ch.now_ms = '0;
    tick_ch.hw_fault = 1'b0;
    res_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: walk every mode but error, time wrap across zero
    add_tick(1'b0, 10'd0, 0, 1'b0);
    add_tick(1'b1, 10'h3FF, 3, 1'b0);
    add_tick(1'b1, 10'd0, 5, 1'b0);
    add_tick(1'b1, 10'd5, 5, 1'b0);
    sim_ms = 32'hFFFF_FF00;
    add_tick(1'b1, 10'd0, 0, 1'b0);
    add_tick(1'b1, 10'd0, 499, 1'b0);
    add_tick(1'b1, 10'd0, 1, 1'b0);
    add_tick(1'b1, 10'd50, 10, 1'b0);
    add_tick(1'b1, 10'd51, 10, 1'b0);
    add_tick(1'b1, 10'h3FF, 10, 1'b0);
    add_tick(1'b1, 10'd0, 10, 1'b0);
    add_tick(1'b1, 10'h3FF, 10, 1'b0);
    add_tick(1'b0, 10'h3FF, 10, 1'b0);
    add_tick(1'b0, 10'd0, 1999, 1'b0);
    add_tick(1'b1, 10'd300, 1, 1'b0);
    add_tick(1'b0, 10'd300, 1, 1'b0);
    add_tick(1'b0, 10'd0, 2000, 1'b0);
    add_tick(1'b1, 10'd0, 199, 1'b0);
    add_tick(1'b0, 10'h3FF, 1, 1'b0);
    add_tick(1'b0, 10'd0, 200, 1'b0);
    sim_ms = 32'hFFFF_FFFF;
    add_tick(1'b1, 10'd0, 0, 1'b0);
    random_flights(200);
    drain();

    load_settings(cfg_t'{16'd0, 16'd0, 16'd0, 7'd0, 10'd0, 7'd0}, 1'b1);
    random_flights(220);
    stall_req++;
    drain();

    load_settings(cfg_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 10'h3FF, 7'h7F}, 1'b0);
    random_flights(150);
    drain();

    sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    load_settings(cfg_t'{16'd200, 16'd500, 16'd10, 7'd1, 10'd100, 7'd40}, 1'b1);
    random_flights(220);
    drain();

    repeat (3) begin
      if ($urandom_range(0, 1) == 0) sim_ms = $urandom;
      load_settings(random_settings(), 1'b1);
      random_flights(240);
      drain();
    end

    quiet = 1'b1;
    load_settings(CFG_RESET, 1'b0);
    random_flights(150);
    add_tick(1'b1, 10'd0, 1, 1'b0);
    hold_span(1'b1, 10'd0, cfg_now.arm_hold_ms);
    add_tick(1'b1, 10'h3FF, 10, 1'b0);
    add_tick(1'b1, 10'd500, 10, 1'b1);
    add_tick(1'b1, 10'd0, 10, 1'b1);
    repeat (6) noise_burst(1'b1);
    drain();
    repeat (10) @(negedge clk);

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // request accepted: predict its result
  always @(posedge clk) begin
    if (tick_ch.valid && tick_ch.ready) begin
      due_results.push_back(sequence_tick(tick_backlog.pop_front()));
      offering = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!offering && !rst) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (tick_backlog.size() != 0) begin
        offering = 1'b1;
        tick_ch.link_active <= tick_backlog[0].link_active;
        tick_ch.throttle <= tick_backlog[0].throttle;
        tick_ch.now_ms <= tick_backlog[0].now_ms;
        tick_ch.hw_fault <= tick_backlog[0].hw_fault;
        if (!quiet && $urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 4);
      end
    end
    tick_ch.valid <= offering;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen = stall_req;
      stall_left = 80;
      res_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 6) == 0) recv_gap = $urandom_range(1, 4);
    end
  end

  task automatic check_field(string name, logic [6:0] want, logic [6:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got mode %0d cmd %0d pct %0d",
                 $time, res_ch.mode, res_ch.motor_cmd, res_ch.motor_pct);
      end else begin
        want = due_results.pop_front();
        check_field("mode", 7'(want.mode), 7'(res_ch.mode));
        check_field("motor_cmd", 7'(want.motor_cmd), 7'(res_ch.motor_cmd));
        check_field("motor_pct", want.motor_pct, res_ch.motor_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
